// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define DMB_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dmb assertion failed");

// next-cycle implication, idle during reset
`define DMB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dmb assertion failed");

// next-cycle implication, also checked across reset
`define DMB_ASSERT_NEXT_NR(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("dmb assertion failed");

`endif

// ===== rtl/dmb_pkg.sv =====
// ----------------------------------------------------------------------------
// dmb_pkg
// Shared types, codes and helpers of the density matrix builder.
// ----------------------------------------------------------------------------
package dmb_pkg;

   localparam int DEF_MAX_BASIS    = 64;
   localparam int DEF_MAX_ORBITALS = 64;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_W            = 7;

   localparam logic [1:0] OP_COEF    = 2'd0;
   localparam logic [1:0] OP_OCC     = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_NUM_BASIS  = 2'd0;
   localparam logic [1:0] CSR_NUM_CLOSED = 2'd1;
   localparam logic [1:0] CSR_NUM_OPEN   = 2'd2;
   localparam logic [1:0] CSR_OPEN_SHELL = 2'd3;

   localparam logic signed [31:0] OCC_MAX = 32'sd32768;

   typedef enum logic [1:0] {
      KIND_COEF    = 2'd0,
      KIND_OCC     = 2'd1,
      KIND_COMPUTE = 2'd2
   } kind_type;

   typedef struct packed {
      logic [CSR_W-1:0] num_basis;
      logic [CSR_W-1:0] num_closed;
      logic [CSR_W-1:0] num_open;
      logic             open_shell;
   } cfg_type;

   function automatic int idx_width(int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic int cnt_width(int maxv);
      return (maxv > 0) ? $clog2(maxv + 1) : 1;
   endfunction

   function automatic int max_int(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int entry_width(int mb, int mo);
      return $bits(kind_type) + 3 * idx_width(mb * mo) + idx_width(mo) + 32
             + idx_width(mb * (mb + 1) / 2) + 1;
   endfunction

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

endpackage

// ===== rtl/dmb_front.sv =====
// ----------------------------------------------------------------------------
// dmb_front
// Decodes request beats, checks ranges, swaps indices and queues work.
// ----------------------------------------------------------------------------
module dmb_front #(
   parameter int  MAX_BASIS    = dmb_pkg::DEF_MAX_BASIS,
   parameter int  MAX_ORBITALS = dmb_pkg::DEF_MAX_ORBITALS,
   localparam int ENTRY_W      = dmb_pkg::entry_width(MAX_BASIS, MAX_ORBITALS)
) (
   input  dmb_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   input  logic [1:0]           req_operation,
   input  logic [5:0]           req_row,
   input  logic [5:0]           req_column,
   input  logic signed [31:0]   req_value,
   input  logic                 clearing,
   input  logic                 q_full,
   output logic                 req_stall,
   output logic                 q_push,
   output logic [ENTRY_W-1:0]   q_data
);
   import dmb_pkg::*;

   localparam int CA_W = idx_width(MAX_BASIS * MAX_ORBITALS);
   localparam int OA_W = idx_width(MAX_ORBITALS);
   localparam int PI_W = idx_width(MAX_BASIS * (MAX_BASIS + 1) / 2);
   localparam int NB_W = max_int(CSR_W, cnt_width(MAX_BASIS));

   typedef struct packed {
      kind_type          kind;
      logic [CA_W-1:0]   waddr;
      logic [OA_W-1:0]   oaddr;
      logic [31:0]       wdata;
      logic [CA_W-1:0]   ibase;
      logic [CA_W-1:0]   jbase;
      logic [PI_W-1:0]   pidx;
      logic              diag;
   } entry_type;

   logic [5:0]      i_idx;
   logic [5:0]      j_idx;
   logic [NB_W-1:0] nb_eff;
   logic [12:0]     tri_sum;
   logic            keep;
   entry_type       ent;

   always_comb begin
      i_idx  = (req_row > req_column) ? req_row : req_column;
      j_idx  = (req_row > req_column) ? req_column : req_row;
      nb_eff = (NB_W'(cfg.num_basis) < NB_W'(MAX_BASIS)) ? NB_W'(cfg.num_basis)
                                                         : NB_W'(MAX_BASIS);
      tri_sum = 13'((13'(i_idx) * (13'(i_idx) + 13'd1)) >> 1) + 13'(j_idx);

      ent.kind  = KIND_COEF;
      ent.waddr = CA_W'(32'(req_row) * 32'(MAX_ORBITALS) + 32'(req_column));
      ent.oaddr = OA_W'(req_column);
      ent.wdata = req_value;
      ent.ibase = CA_W'(32'(i_idx) * 32'(MAX_ORBITALS));
      ent.jbase = CA_W'(32'(j_idx) * 32'(MAX_ORBITALS));
      ent.pidx  = PI_W'(tri_sum);
      ent.diag  = (i_idx == j_idx);
      keep      = 1'b0;

      unique case (req_operation)
         OP_COEF: begin
            ent.kind = KIND_COEF;
            keep = (32'(req_row) < 32'(MAX_BASIS)) && (32'(req_column) < 32'(MAX_ORBITALS));
         end
         OP_OCC: begin
            ent.kind = KIND_OCC;
            keep = (32'(req_column) < 32'(MAX_ORBITALS));
            if (req_value < 0) begin
               ent.wdata = '0;
            end else if (req_value > OCC_MAX) begin
               ent.wdata = OCC_MAX;
            end
         end
         OP_COMPUTE: begin
            ent.kind = KIND_COMPUTE;
            keep = (NB_W'(i_idx) < nb_eff);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = clearing | q_full;
   assign q_push    = req_valid & ~req_stall & keep;
   assign q_data    = ent;

endmodule

// ===== rtl/dmb_queue.sv =====
// ----------------------------------------------------------------------------
// dmb_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module dmb_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = dmb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] head
);
   import dmb_pkg::*;

   localparam int PW = idx_width(DEPTH);
   localparam int CW = cnt_width(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + PW'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + PW'(1));
      end
      if (push && !pop) begin
         count_in = CW'(count_ff + CW'(1));
      end else if (pop && !push) begin
         count_in = CW'(count_ff - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/dmb_back.sv =====
// ----------------------------------------------------------------------------
// dmb_back
// Owns the stores and runs the per-orbital multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module dmb_back #(
   parameter int  MAX_BASIS    = dmb_pkg::DEF_MAX_BASIS,
   parameter int  MAX_ORBITALS = dmb_pkg::DEF_MAX_ORBITALS,
   localparam int ENTRY_W      = dmb_pkg::entry_width(MAX_BASIS, MAX_ORBITALS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dmb_pkg::cfg_type     cfg,
   input  logic                 q_empty,
   input  logic [ENTRY_W-1:0]   q_head,
   output logic                 q_pop,
   output logic                 clearing,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [11:0]          rsp_packed_index,
   output logic signed [63:0]   rsp_total_density,
   output logic signed [63:0]   rsp_total_delta,
   output logic signed [63:0]   rsp_open_density,
   output logic signed [63:0]   rsp_open_delta
);
   import dmb_pkg::*;

   localparam int CA_D = MAX_BASIS * MAX_ORBITALS;
   localparam int PD   = MAX_BASIS * (MAX_BASIS + 1) / 2;
   localparam int CA_W = idx_width(CA_D);
   localparam int OA_W = idx_width(MAX_ORBITALS);
   localparam int PI_W = idx_width(PD);
   localparam int OC_W = cnt_width(MAX_ORBITALS);
   localparam int NC_W = max_int(CSR_W, OC_W);

   typedef struct packed {
      kind_type          kind;
      logic [CA_W-1:0]   waddr;
      logic [OA_W-1:0]   oaddr;
      logic [31:0]       wdata;
      logic [CA_W-1:0]   ibase;
      logic [CA_W-1:0]   jbase;
      logic [PI_W-1:0]   pidx;
      logic              diag;
   } entry_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_FETCH = 5'b10000
   } state_type;

   entry_type          head;
   state_type          state_ff, state_in;
   entry_type          cur_ff, cur_in;
   logic [OC_W-1:0]    k_ff, k_in;
   logic [PI_W-1:0]    clr_ff, clr_in;
   logic [NC_W-1:0]    nc, no_cnt;
   logic [OC_W-1:0]    n_eff;

   logic signed [31:0] coef_mem [CA_D];
   logic [15:0]        occ_mem [MAX_ORBITALS];
   logic signed [63:0] ptot_mem [PD];
   logic signed [63:0] popen_mem [PD];

   logic signed [31:0] ci_ff, cj_ff;
   logic [15:0]        occ_rd_ff, occ2_ff;
   logic signed [63:0] ptot_rd_ff, popen_rd_ff;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [63:0] p_ff, p_in;
   logic [47:0]        lo3_ff, lo_in;
   logic signed [48:0] hi3_ff, hi_in;
   logic signed [63:0] cterm3_ff, cterm_in;
   logic signed [80:0] full_prod, shifted;
   logic signed [63:0] term4_ff, term_in;
   logic signed [63:0] acc_c_ff, acc_o_ff;

   logic               issue, start, prev_rd, cw_en, ow_en;
   logic               pw_en, pw_open_en, load_rsp;
   logic [PI_W-1:0]    pw_addr;
   logic signed [63:0] pw_tot, pw_open;
   logic signed [63:0] total, tdelta, odens, odelta;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [11:0]        rsp_index_ff;
   logic signed [63:0] rsp_tot_ff, rsp_tdelta_ff, rsp_odens_ff, rsp_odelta_ff;

   assign head = q_head;

   always_comb begin
      nc     = (NC_W'(cfg.num_closed) < NC_W'(MAX_ORBITALS)) ? NC_W'(cfg.num_closed)
                                                             : NC_W'(MAX_ORBITALS);
      no_cnt = (NC_W'(cfg.num_open) < NC_W'(NC_W'(MAX_ORBITALS) - nc))
               ? NC_W'(cfg.num_open) : NC_W'(NC_W'(MAX_ORBITALS) - nc);
      n_eff  = OC_W'(nc + no_cnt);
   end

   always_comb begin
      total  = sat_add(acc_c_ff, acc_o_ff);
      tdelta = sat_sub(total, ptot_rd_ff);
      odens  = cfg.open_shell ? acc_o_ff : '0;
      odelta = cfg.open_shell ? sat_sub(acc_o_ff, popen_rd_ff) : '0;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      clr_in       = clr_ff;
      q_pop        = 1'b0;
      issue        = 1'b0;
      start        = 1'b0;
      prev_rd      = 1'b0;
      pw_en        = 1'b0;
      pw_open_en   = 1'b0;
      pw_addr      = clr_ff;
      pw_tot       = '0;
      pw_open      = '0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         ST_CLEAR: begin
            pw_en      = 1'b1;
            pw_open_en = 1'b1;
            clr_in     = PI_W'(clr_ff + PI_W'(1));
            if (clr_ff == PI_W'(PD - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (head.kind == KIND_COMPUTE) begin
                  cur_in   = head;
                  k_in     = '0;
                  start    = 1'b1;
                  state_in = (n_eff == '0) ? ST_DRAIN : ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            k_in  = OC_W'(k_ff + OC_W'(1));
            if (OC_W'(k_ff + OC_W'(1)) == n_eff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(v1_ff | v2_ff | v3_ff | v4_ff)) begin
               prev_rd  = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp     = 1'b1;
               pw_en        = 1'b1;
               pw_open_en   = cfg.open_shell;
               pw_addr      = cur_ff.pidx;
               pw_tot       = total;
               pw_open      = acc_o_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      cw_en = state_ff[0] == 1'b0 && state_ff == ST_IDLE && !q_empty
              && head.kind == KIND_COEF;
      ow_en = state_ff == ST_IDLE && !q_empty && head.kind == KIND_OCC;
   end

   // multiply-accumulate datapath
   always_comb begin
      p_in      = 64'(ci_ff) * 64'(cj_ff);
      lo_in     = 48'(p_ff[31:0]) * 48'(occ2_ff);
      hi_in     = 49'($signed(p_ff[63:32])) * 49'($signed({1'b0, occ2_ff}));
      cterm_in  = cur_ff.diag ? (p_ff >>> 13) : (p_ff >>> 12);
      full_prod = $signed({hi3_ff, 32'd0}) + $signed({33'd0, lo3_ff});
      shifted   = cur_ff.diag ? (full_prod >>> 28) : (full_prod >>> 27);
      term_in   = c3_ff ? cterm3_ff : shifted[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      c1_ff     <= (NC_W'(k_ff) < nc);
      c2_ff     <= c1_ff;
      c3_ff     <= c2_ff;
      c4_ff     <= c3_ff;
      p_ff      <= p_in;
      occ2_ff   <= occ_rd_ff;
      lo3_ff    <= lo_in;
      hi3_ff    <= hi_in;
      cterm3_ff <= cterm_in;
      term4_ff  <= term_in;
      if (start) begin
         acc_c_ff <= '0;
         acc_o_ff <= '0;
      end else if (v4_ff) begin
         if (c4_ff) begin
            acc_c_ff <= sat_add(acc_c_ff, term4_ff);
         end else begin
            acc_o_ff <= sat_add(acc_o_ff, term4_ff);
         end
      end
      if (load_rsp) begin
         rsp_index_ff  <= 12'(cur_ff.pidx);
         rsp_tot_ff    <= total;
         rsp_tdelta_ff <= tdelta;
         rsp_odens_ff  <= odens;
         rsp_odelta_ff <= odelta;
      end
   end

   // coefficient store, one write and two reads per cycle
   always_ff @(posedge clock) begin
      if (cw_en) begin
         coef_mem[head.waddr] <= head.wdata;
      end
      ci_ff <= coef_mem[cur_ff.ibase + CA_W'(k_ff)];
      cj_ff <= coef_mem[cur_ff.jbase + CA_W'(k_ff)];
   end

   // occupation store
   always_ff @(posedge clock) begin
      if (ow_en) begin
         occ_mem[head.oaddr] <= head.wdata[15:0];
      end
      occ_rd_ff <= occ_mem[k_ff[OA_W-1:0]];
   end

   // previous density stores
   always_ff @(posedge clock) begin
      if (pw_en) begin
         ptot_mem[pw_addr] <= pw_tot;
      end
      if (pw_en && pw_open_en) begin
         popen_mem[pw_addr] <= pw_open;
      end
      if (prev_rd) begin
         ptot_rd_ff  <= ptot_mem[cur_ff.pidx];
         popen_rd_ff <= popen_mem[cur_ff.pidx];
      end
   end

   assign clearing          = (state_ff == ST_CLEAR);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packed_index  = rsp_index_ff;
   assign rsp_total_density = rsp_tot_ff;
   assign rsp_total_delta   = rsp_tdelta_ff;
   assign rsp_open_density  = rsp_odens_ff;
   assign rsp_open_delta    = rsp_odelta_ff;

endmodule

// ===== rtl/density_matrix_builder_core.sv =====
// ----------------------------------------------------------------------------
// density_matrix_builder_core
// Packed lower-triangle density matrix element builder, closed and open shell.
// compute beat: its n orbitals, n = closed plus open orbitals, go one orbital a
//   cycle through the shared multiply-accumulate; store writes are registered
// after reset, a clearing pass zeroes the previous density stores while
//   req_stall is held high
// ----------------------------------------------------------------------------
module density_matrix_builder_core #(
   parameter int MAX_BASIS    = dmb_pkg::DEF_MAX_BASIS,
   parameter int MAX_ORBITALS = dmb_pkg::DEF_MAX_ORBITALS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [dmb_pkg::CSR_W-1:0]   csr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [5:0]                  req_row,
   input  logic [5:0]                  req_column,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [11:0]                 rsp_packed_index,
   output logic signed [63:0]          rsp_total_density,
   output logic signed [63:0]          rsp_total_delta,
   output logic signed [63:0]          rsp_open_density,
   output logic signed [63:0]          rsp_open_delta
);
   import dmb_pkg::*;

   localparam int ENTRY_W = entry_width(MAX_BASIS, MAX_ORBITALS);

   cfg_type            cfg_ff;
   logic               clearing;
   logic               q_push, q_pop, q_full, q_empty;
   logic [ENTRY_W-1:0] q_data, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{num_basis: CSR_W'(1), default: '0};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NUM_BASIS:  cfg_ff.num_basis  <= csr_data;
            CSR_NUM_CLOSED: cfg_ff.num_closed <= csr_data;
            CSR_NUM_OPEN:   cfg_ff.num_open   <= csr_data;
            CSR_OPEN_SHELL: cfg_ff.open_shell <= csr_data[0];
         endcase
      end
   end

   dmb_front #(
      .MAX_BASIS    (MAX_BASIS),
      .MAX_ORBITALS (MAX_ORBITALS)
   ) u_front (
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_row       (req_row),
      .req_column    (req_column),
      .req_value     (req_value),
      .clearing      (clearing),
      .q_full        (q_full),
      .req_stall     (req_stall),
      .q_push        (q_push),
      .q_data        (q_data)
   );

   dmb_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   dmb_back #(
      .MAX_BASIS    (MAX_BASIS),
      .MAX_ORBITALS (MAX_ORBITALS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_packed_index  (rsp_packed_index),
      .rsp_total_density (rsp_total_density),
      .rsp_total_delta   (rsp_total_delta),
      .rsp_open_density  (rsp_open_density),
      .rsp_open_delta    (rsp_open_delta)
   );

endmodule

// ===== rtl/dmb_checker.sv =====
// ----------------------------------------------------------------------------
// dmb_checker
// Port-level checks of the density matrix builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        csr_write,
   input logic [1:0]                  csr_index,
   input logic [dmb_pkg::CSR_W-1:0]   csr_data,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [63:0]          rsp_total_density,
   input logic signed [63:0]          rsp_open_density,
   input logic signed [63:0]          rsp_open_delta
);
   import dmb_pkg::*;

   logic open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (csr_write && csr_index == CSR_OPEN_SHELL) begin
         open_ff <= csr_data[0];
      end
   end

   `DMB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_total_density))
   `DMB_ASSERT_NEXT_NR(a_clear_after_reset, reset, req_stall)
   `DMB_ASSERT(a_open_off_zero, rsp_valid && !open_ff, rsp_open_density == 0 && rsp_open_delta == 0)

endmodule

bind density_matrix_builder_core dmb_checker u_dmb_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for density_matrix_builder_core. Coefficient and
// occupation writes and element computes are streamed through the request
// channel under random gaps and response stalls. An in-bench density model
// predicts every element beat, which is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dmb_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [31:0] value;
   } req_beat_t;

   typedef struct {
      logic [11:0]        packed_index;
      logic signed [63:0] total_density;
      logic signed [63:0] total_delta;
      logic signed [63:0] open_density;
      logic signed [63:0] open_delta;
   } element_t;

   logic clock, reset;
   logic csr_write;
   logic [1:0] csr_index;
   logic [CSR_W-1:0] csr_data;
   logic req_valid, req_stall;
   logic [1:0] req_operation;
   logic [5:0] req_row, req_column;
   logic signed [31:0] req_value;
   logic rsp_valid, rsp_stall;
   logic [11:0] rsp_packed_index;
   logic signed [63:0] rsp_total_density, rsp_total_delta;
   logic signed [63:0] rsp_open_density, rsp_open_delta;

   density_matrix_builder_core dut (.*);

   // model state
   logic signed [31:0] coef_mem [0:63][0:63];
   logic [15:0]        occ_mem [0:63];
   logic signed [63:0] prev_total [0:2079];
   logic signed [63:0] prev_open [0:2079];
   int unsigned m_basis, m_closed, m_open, m_shell;

   // generator bookkeeping
   bit coef_known [0:63][0:63];
   bit occ_known [0:63];

   req_beat_t pending_beats[$];
   element_t  expected_elements[$];
   int fail_count, beats_in, elements_seen, computes_sent, writes_sent, phases_run;
   bit quiet, long_hold_done;
   int req_gap, rsp_gap, long_hold;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("density_matrix_builder_core regression: fail");
      $finish;
   end

   function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                    logic signed [63:0] b,
                                                    bit sub);
      logic signed [64:0] s;
      s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   function automatic void apply_beat(req_beat_t b);
      int unsigned i, j, nb, nc, no, idx;
      logic signed [63:0] p, closed, open, total;
      logic signed [127:0] w;
      element_t e;
      bit diag;
      case (b.op)
         OP_COEF: coef_mem[b.row][b.col] = b.value;
         OP_OCC: begin
            if (b.value < 0) occ_mem[b.col] = 16'd0;
            else if (b.value > OCC_MAX) occ_mem[b.col] = 16'd32768;
            else occ_mem[b.col] = b.value[15:0];
         end
         OP_COMPUTE: begin
            i = (b.row > b.col) ? b.row : b.col;
            j = (b.row > b.col) ? b.col : b.row;
            nb = (m_basis < 64) ? m_basis : 64;
            if (i >= nb) return;
            nc = (m_closed < 64) ? m_closed : 64;
            no = (m_open < 64 - nc) ? m_open : 64 - nc;
            diag = (i == j);
            closed = 0;
            open = 0;
            for (int k = 0; k < nc + no; k++) begin
               p = 64'(coef_mem[i][k]) * 64'(coef_mem[j][k]);
               if (k < nc) begin
                  closed = clamp_add(closed, p >>> (diag ? 13 : 12), 0);
               end else begin
                  w = 128'(p) * $signed({112'd0, occ_mem[k]});
                  w = w >>> (diag ? 28 : 27);
                  open = clamp_add(open, w[63:0], 0);
               end
            end
            idx = i * (i + 1) / 2 + j;
            total = clamp_add(closed, open, 0);
            e.packed_index = idx[11:0];
            e.total_density = total;
            e.total_delta = clamp_add(total, prev_total[idx], 1);
            prev_total[idx] = total;
            e.open_density = 0;
            e.open_delta = 0;
            if (m_shell != 0) begin
               e.open_density = open;
               e.open_delta = clamp_add(open, prev_open[idx], 1);
               prev_open[idx] = open;
            end
            expected_elements.push_back(e);
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   // request driver
   always @(posedge clock) begin
      req_beat_t nb;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_beat('{req_operation, req_row, req_column, req_value});
            beats_in++;
         end
         if (req_valid && req_stall) begin
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            nb = pending_beats.pop_front();
            req_operation <= nb.op;
            req_row <= nb.row;
            req_column <= nb.col;
            req_value <= nb.value;
            req_valid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // response monitor and stall
   always @(posedge clock) begin
      element_t e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
         long_hold <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            elements_seen++;
            if (expected_elements.size() == 0) begin
               $error("unexpected element beat at index %0d", rsp_packed_index);
               fail_count++;
            end else begin
               e = expected_elements.pop_front();
               check_field("packed_index", 64'(e.packed_index), 64'(rsp_packed_index));
               check_field("total_density", e.total_density, rsp_total_density);
               check_field("total_delta", e.total_delta, rsp_total_delta);
               check_field("open_density", e.open_density, rsp_open_density);
               check_field("open_delta", e.open_delta, rsp_open_delta);
            end
         end
         if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && beats_in >= 300) begin
            long_hold_done <= 1'b1;
            long_hold <= 400;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_gap <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_valid || expected_elements.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic set_config(int unsigned nb, int unsigned nc, int unsigned no,
                             int unsigned os);
      logic [1:0] idx [4];
      int unsigned val [4];
      idx = '{CSR_NUM_BASIS, CSR_NUM_CLOSED, CSR_NUM_OPEN, CSR_OPEN_SHELL};
      val = '{nb, nc, no, os};
      for (int n = 0; n < 4; n++) begin
         @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= idx[n];
         csr_data <= val[n][CSR_W-1:0];
      end
      @(posedge clock);
      csr_write <= 1'b0;
      m_basis = nb;
      m_closed = nc;
      m_open = no;
      m_shell = os;
      phases_run++;
   endtask

   function automatic logic signed [31:0] rand_coef();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $signed(32'($urandom_range(0, 32'h1000_0000))) - 32'sh0800_0000;
      if (r < 65) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      return $urandom();
   endfunction

   function automatic logic signed [31:0] rand_occ();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 32768);
      if (r < 55) return ($urandom_range(0, 1) != 0) ? 32'sd32768 : 32'sd0;
      if (r < 75) return -$signed(32'($urandom_range(1, 32'h7FFF_FFFF)));
      return $urandom_range(32769, 32'h7FFF_FFFF);
   endfunction

   function automatic void push(logic [1:0] op, int unsigned r, int unsigned c,
                                logic signed [31:0] v);
      pending_beats.push_back('{op, r[5:0], c[5:0], v});
      if (op == OP_COEF) begin
         coef_known[r][c] = 1;
         writes_sent++;
      end else if (op == OP_OCC) begin
         occ_known[c] = 1;
         writes_sent++;
      end else if (op == OP_COMPUTE) begin
         computes_sent++;
      end
   endfunction

   function automatic int prepare_rows(int unsigned i, int unsigned j, int unsigned n,
                                       int unsigned nc);
      int added;
      added = 0;
      for (int k = 0; k < n; k++) begin
         if (!coef_known[i][k]) begin push(OP_COEF, i, k, rand_coef()); added++; end
         if (!coef_known[j][k]) begin push(OP_COEF, j, k, rand_coef()); added++; end
         if (k >= nc && !occ_known[k]) begin push(OP_OCC, 0, k, rand_occ()); added++; end
      end
      return added;
   endfunction

   function automatic void compute(int unsigned i, int unsigned j, int unsigned n,
                                   int unsigned nc);
      void'(prepare_rows(i, j, n, nc));
      if ($urandom_range(0, 1) != 0) push(OP_COMPUTE, i, j, $urandom());
      else push(OP_COMPUTE, j, i, $urandom());
   endfunction

   task automatic run_phase(int unsigned nb, int unsigned nc, int unsigned no,
                            int unsigned os, int items);
      int unsigned n, i, j, ncl;
      int made, r;
      wait_idle();
      set_config(nb, nc, no, os);
      ncl = (nc < 64) ? nc : 64;
      n = ncl + ((no < 64 - ncl) ? no : 64 - ncl);
      made = 0;
      while (made < items) begin
         r = $urandom_range(0, 99);
         i = $urandom_range(0, nb - 1);
         j = $urandom_range(0, nb - 1);
         if (r < 45) begin
            compute(i, j, n, ncl);
            made++;
         end else if (r < 68) begin
            push(OP_COEF, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : i,
                 $urandom_range(0, 63), rand_coef());
            made++;
         end else if (r < 80) begin
            push(OP_OCC, $urandom_range(0, 63), $urandom_range(0, 63), rand_occ());
            made++;
         end else if (r < 90) begin
            compute(i, i, n, ncl);
            made++;
         end else if (r < 95 || nb >= 64) begin
            push(2'd3, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
         end else begin
            push(OP_COMPUTE, $urandom_range(nb, 63), $urandom_range(0, 63), $urandom());
         end
      end
   endtask

   initial begin
      int unsigned nb, nc, no;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_operation = '0;
      req_row = '0;
      req_column = '0;
      req_value = '0;
      rsp_stall = 1'b0;
      fail_count = 0;
      for (int n = 0; n < 2080; n++) begin
         prev_total[n] = '0;
         prev_open[n] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: small open-shell case, swaps, diagonal, field extremes
      set_config(4, 2, 1, 1);
      push(OP_COEF, 0, 0, 32'sh7FFF_FFFF);
      push(OP_COEF, 1, 0, 32'sh8000_0000);
      push(OP_COEF, 0, 1, 32'sh8000_0000);
      push(OP_COEF, 1, 1, 32'sh8000_0000);
      push(OP_COEF, 0, 2, 32'sh0800_0000);
      push(OP_COEF, 1, 2, -32'sh0800_0000);
      push(OP_OCC, 0, 2, -32'sd5);
      push(OP_COMPUTE, 0, 1, 0);
      push(OP_COMPUTE, 1, 0, 0);
      push(OP_COMPUTE, 1, 1, 0);
      push(OP_OCC, 63, 2, 32'sh7FFF_FFFF);
      push(OP_COMPUTE, 1, 0, 0);
      push(OP_OCC, 0, 2, 32'sd32768);
      push(OP_COMPUTE, 0, 0, 0);
      push(OP_COMPUTE, 63, 63, 32'sh7FFF_FFFF);
      push(2'd3, 63, 63, 32'sh8000_0000);
      push(OP_COEF, 63, 63, 32'sh7FFF_FFFF);
      push(OP_OCC, 0, 63, 32'sd32769);
      push(OP_OCC, 0, 63, 32'sd0);
      wait_idle();
      // open shell off: open orbitals still counted in the total
      set_config(4, 2, 1, 0);
      push(OP_COMPUTE, 1, 0, 0);
      push(OP_COMPUTE, 0, 0, 0);
      wait_idle();
      set_config(1, 0, 0, 0);
      push(OP_COMPUTE, 0, 0, 0);
      push(OP_COMPUTE, 1, 0, 0);

      // extremes of size: full basis, all 64 orbitals, open count clamped
      run_phase(64, 40, 64, 1, 0);
      compute(63, 63, 64, 40);
      compute(63, 0, 64, 40);
      quiet = 1;
      run_phase(8, 3, 2, 1, 80);
      quiet = 0;
      run_phase(16, 5, 3, 1, 150);
      for (int p = 0; p < 7; p++) begin
         nb = $urandom_range(1, 16);
         nc = $urandom_range(0, 6);
         no = $urandom_range(0, 6);
         run_phase(nb, nc, no, $urandom_range(0, 1), 35);
      end
      run_phase(1, 1, 0, 0, 20);
      wait_idle();
      repeat (100) @(posedge clock);

      $display("covered %0d config phases, %0d store writes, %0d element computes",
               phases_run, writes_sent, computes_sent);
      $display("%0d element beats checked, %0d mismatches", elements_seen, fail_count);
      if (fail_count == 0 && expected_elements.size() == 0) begin
         $display("density_matrix_builder_core regression: pass");
      end else begin
         $display("density_matrix_builder_core regression: fail");
      end
      $finish;
   end

endmodule
